@@ hw/rtl/sm83_alu_with_flags_unit_defines.svh @@
// Assertion macros used by the ALU unit.
`ifndef SM83_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
`define SM83_ALU_WITH_FLAGS_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SM83_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sm83 alu: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SM83_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sm83 alu: next-cycle check failed");

`endif

@@ hw/rtl/sm83alu_pkg.sv @@
`timescale 1ns / 1ps

package sm83alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD     = 5'd0,
    OP_ADC     = 5'd1,
    OP_SUB     = 5'd2,
    OP_SBC     = 5'd3,
    OP_AND     = 5'd4,
    OP_OR      = 5'd5,
    OP_XOR     = 5'd6,
    OP_CP      = 5'd7,
    OP_INC     = 5'd8,
    OP_DEC     = 5'd9,
    OP_RLC     = 5'd10,
    OP_RRC     = 5'd11,
    OP_RL      = 5'd12,
    OP_RR      = 5'd13,
    OP_SLA     = 5'd14,
    OP_SRA     = 5'd15,
    OP_SWAP    = 5'd16,
    OP_SRL     = 5'd17,
    OP_BIT     = 5'd18,
    OP_RES     = 5'd19,
    OP_SET     = 5'd20,
    OP_DAA     = 5'd21,
    OP_CPL     = 5'd22,
    OP_CCF     = 5'd23,
    OP_SCF     = 5'd24,
    OP_RLCA    = 5'd25,
    OP_RRCA    = 5'd26,
    OP_RLA     = 5'd27,
    OP_RRA     = 5'd28,
    OP_ADD_HL  = 5'd29,
    OP_ADD_SP  = 5'd30
  } kind_e;

  // Flag bit positions within the 4-bit flag word
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // Decimal adjust constants
  localparam logic [7:0] DaaHiAdj    = 8'h60;
  localparam logic [7:0] DaaLoAdj    = 8'h06;
  localparam logic [7:0] DaaHiLimit  = 8'h99;
  localparam logic [3:0] DaaLoLimit  = 4'h9;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  accumulator;
    logic [7:0]  operand;
    logic [3:0]  flags_in;
    logic [2:0]  bit_index;
    logic [15:0] wide_base;
    logic [15:0] wide_operand;
  } alu_in_t;

  typedef struct packed {
    logic [7:0]  result;
    logic [15:0] wide_result;
    logic [3:0]  flags_out;
    logic        write_back;
  } alu_out_t;

endpackage

@@ hw/rtl/sm83_alu_with_flags_unit.sv @@
`timescale 1ns / 1ps

// SM83 ALU with flags: takes one operation per cycle while in_stall_o is low
// and returns its 8-bit result, 16-bit result, new Z N H C flags and
// write-back strobe. An item transferred on the input is held in the input
// register and is then clocked through a single pass of the ALU logic into
// the result register, from which it leaves when out_stall_i is low.
// Sustained rate is one item per cycle while out_stall_i is low, set by the
// two registers advancing together; in_stall_o rises only when both registers
// are full and out_stall_i is high. There is no state between items and no
// configuration.
`include "sm83_alu_with_flags_unit_defines.svh"

module sm83_alu_with_flags_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  kind_i,
  input  logic [7:0]  accumulator_i,
  input  logic [7:0]  operand_i,
  input  logic [3:0]  flags_in_i,
  input  logic [2:0]  bit_index_i,
  input  logic [15:0] wide_base_i,
  input  logic [15:0] wide_operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  result_o,
  output logic [15:0] wide_result_o,
  output logic [3:0]  flags_out_o,
  output logic        write_back_o
);

  logic                 s1_valid_d, s1_valid_q;
  logic                 out_valid_d, out_valid_q;
  sm83alu_pkg::alu_in_t  s1_q;
  sm83alu_pkg::alu_out_t alu_res;
  sm83alu_pkg::alu_out_t out_q;
  logic                 out_ready;
  logic                 in_xfer;
  logic                 s1_adv;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q.kind         <= kind_i;
      s1_q.accumulator  <= accumulator_i;
      s1_q.operand      <= operand_i;
      s1_q.flags_in     <= flags_in_i;
      s1_q.bit_index    <= bit_index_i;
      s1_q.wide_base    <= wide_base_i;
      s1_q.wide_operand <= wide_operand_i;
    end
    if (s1_adv) begin
      out_q <= alu_res;
    end
  end

  // ALU datapath
  logic [7:0]  a, b;
  logic [3:0]  f;
  logic        cin;
  logic        tin;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  dif9;
  logic [4:0]  dif_lo;
  logic [7:0]  rot_src;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_add, daa_sub;
  logic        daa_c;
  logic [16:0] hl_sum;
  logic [12:0] hl_lo;
  logic [15:0] sp_ext;
  logic [8:0]  sp_lo8;
  logic [4:0]  sp_lo4;
  logic [7:0]  r;
  logic [15:0] w;
  logic        zf, nf, hf, cf;
  logic        wr;
  logic        use_zf;
  sm83alu_pkg::kind_e k;

  assign a   = s1_q.accumulator;
  assign b   = s1_q.operand;
  assign f   = s1_q.flags_in;
  assign cin = f[sm83alu_pkg::FlagC];
  assign k   = sm83alu_pkg::kind_e'(s1_q.kind);

  always_comb begin
    tin      = ((k == sm83alu_pkg::OP_ADC) || (k == sm83alu_pkg::OP_SBC)) ? cin : 1'b0;
    sum9     = {1'b0, a} + {1'b0, b} + {8'd0, tin};
    sum_lo   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, tin};
    dif9     = {1'b0, a} - {1'b0, b} - {8'd0, tin};
    dif_lo   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, tin};
    rot_src  = ((k == sm83alu_pkg::OP_RLCA) || (k == sm83alu_pkg::OP_RRCA) ||
                (k == sm83alu_pkg::OP_RLA) || (k == sm83alu_pkg::OP_RRA)) ? a : b;
    bit_mask = 8'd1 << s1_q.bit_index;

    daa_c   = cin || (a > sm83alu_pkg::DaaHiLimit);
    daa_add = a + (daa_c ? sm83alu_pkg::DaaHiAdj : 8'd0)
                + ((f[sm83alu_pkg::FlagH] || (a[3:0] > sm83alu_pkg::DaaLoLimit)) ?
                   sm83alu_pkg::DaaLoAdj : 8'd0);
    daa_sub = a - (cin ? sm83alu_pkg::DaaHiAdj : 8'd0)
                - (f[sm83alu_pkg::FlagH] ? sm83alu_pkg::DaaLoAdj : 8'd0);

    hl_sum = {1'b0, s1_q.wide_base} + {1'b0, s1_q.wide_operand};
    hl_lo  = {1'b0, s1_q.wide_base[11:0]} + {1'b0, s1_q.wide_operand[11:0]};
    sp_ext = {{8{b[7]}}, b};
    sp_lo8 = {1'b0, s1_q.wide_base[7:0]} + {1'b0, b};
    sp_lo4 = {1'b0, s1_q.wide_base[3:0]} + {1'b0, b[3:0]};
  end

  always_comb begin
    r      = a;
    w      = '0;
    zf     = f[sm83alu_pkg::FlagZ];
    nf     = f[sm83alu_pkg::FlagN];
    hf     = f[sm83alu_pkg::FlagH];
    cf     = cin;
    wr     = 1'b1;
    use_zf = 1'b0;
    unique case (k) inside
      sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
        r = sum9[7:0]; use_zf = 1'b1; nf = 1'b0; hf = sum_lo[4]; cf = sum9[8];
      end
      sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC, sm83alu_pkg::OP_CP: begin
        r = dif9[7:0]; use_zf = 1'b1; nf = 1'b1; hf = dif_lo[4]; cf = dif9[8];
        wr = (k != sm83alu_pkg::OP_CP);
      end
      sm83alu_pkg::OP_AND: begin
        r = a & b; use_zf = 1'b1; nf = 1'b0; hf = 1'b1; cf = 1'b0;
      end
      sm83alu_pkg::OP_OR: begin
        r = a | b; use_zf = 1'b1; nf = 1'b0; hf = 1'b0; cf = 1'b0;
      end
      sm83alu_pkg::OP_XOR: begin
        r = a ^ b; use_zf = 1'b1; nf = 1'b0; hf = 1'b0; cf = 1'b0;
      end
      sm83alu_pkg::OP_INC: begin
        r = b + 8'd1; use_zf = 1'b1; nf = 1'b0; hf = (b[3:0] == 4'hF);
      end
      sm83alu_pkg::OP_DEC: begin
        r = b - 8'd1; use_zf = 1'b1; nf = 1'b1; hf = (b[3:0] == 4'h0);
      end
      sm83alu_pkg::OP_RLC, sm83alu_pkg::OP_RLCA: begin
        r = {rot_src[6:0], rot_src[7]}; cf = rot_src[7]; nf = 1'b0; hf = 1'b0;
        use_zf = (k == sm83alu_pkg::OP_RLC); zf = 1'b0;
      end
      sm83alu_pkg::OP_RRC, sm83alu_pkg::OP_RRCA: begin
        r = {rot_src[0], rot_src[7:1]}; cf = rot_src[0]; nf = 1'b0; hf = 1'b0;
        use_zf = (k == sm83alu_pkg::OP_RRC); zf = 1'b0;
      end
      sm83alu_pkg::OP_RL, sm83alu_pkg::OP_RLA: begin
        r = {rot_src[6:0], cin}; cf = rot_src[7]; nf = 1'b0; hf = 1'b0;
        use_zf = (k == sm83alu_pkg::OP_RL); zf = 1'b0;
      end
      sm83alu_pkg::OP_RR, sm83alu_pkg::OP_RRA: begin
        r = {cin, rot_src[7:1]}; cf = rot_src[0]; nf = 1'b0; hf = 1'b0;
        use_zf = (k == sm83alu_pkg::OP_RR); zf = 1'b0;
      end
      sm83alu_pkg::OP_SLA: begin
        r = {b[6:0], 1'b0}; cf = b[7]; nf = 1'b0; hf = 1'b0; use_zf = 1'b1;
      end
      sm83alu_pkg::OP_SRA: begin
        r = {b[7], b[7:1]}; cf = b[0]; nf = 1'b0; hf = 1'b0; use_zf = 1'b1;
      end
      sm83alu_pkg::OP_SWAP: begin
        r = {b[3:0], b[7:4]}; cf = 1'b0; nf = 1'b0; hf = 1'b0; use_zf = 1'b1;
      end
      sm83alu_pkg::OP_SRL: begin
        r = {1'b0, b[7:1]}; cf = b[0]; nf = 1'b0; hf = 1'b0; use_zf = 1'b1;
      end
      sm83alu_pkg::OP_BIT: begin
        r = b; wr = 1'b0; zf = ((b & bit_mask) == 8'd0); nf = 1'b0; hf = 1'b1;
      end
      sm83alu_pkg::OP_RES: begin
        r = b & ~bit_mask;
      end
      sm83alu_pkg::OP_SET: begin
        r = b | bit_mask;
      end
      sm83alu_pkg::OP_DAA: begin
        // after a subtraction only undo the adjust; after an add derive it
        r  = f[sm83alu_pkg::FlagN] ? daa_sub : daa_add;
        cf = f[sm83alu_pkg::FlagN] ? cin : daa_c;
        hf = 1'b0; use_zf = 1'b1;
      end
      sm83alu_pkg::OP_CPL: begin
        r = ~a; nf = 1'b1; hf = 1'b1;
      end
      sm83alu_pkg::OP_CCF: begin
        wr = 1'b0; nf = 1'b0; hf = 1'b0; cf = ~cin;
      end
      sm83alu_pkg::OP_SCF: begin
        wr = 1'b0; nf = 1'b0; hf = 1'b0; cf = 1'b1;
      end
      sm83alu_pkg::OP_ADD_HL: begin
        r = '0; w = hl_sum[15:0]; nf = 1'b0; hf = hl_lo[12]; cf = hl_sum[16];
      end
      sm83alu_pkg::OP_ADD_SP: begin
        r = '0; w = s1_q.wide_base + sp_ext;
        zf = 1'b0; nf = 1'b0; hf = sp_lo4[4]; cf = sp_lo8[8];
      end
      default: begin
        wr = 1'b0;
      end
    endcase
    if (use_zf) begin
      zf = (r == 8'd0);
    end
  end

  assign alu_res.result      = r;
  assign alu_res.wide_result = w;
  assign alu_res.flags_out   = {zf, nf, hf, cf};
  assign alu_res.write_back  = wr;

  assign out_valid_o   = out_valid_q;
  assign result_o      = out_q.result;
  assign wide_result_o = out_q.wide_result;
  assign flags_out_o   = out_q.flags_out;
  assign write_back_o  = out_q.write_back;

  `SM83_ASSERT_IMPL(a_stall_needs_item, in_stall_o, s1_valid_q && out_valid_q)
  `SM83_ASSERT_NEXT(a_in_xfer_loads, in_valid_i && !in_stall_o, s1_valid_q)
  `SM83_ASSERT_NEXT(a_drain_empties, out_valid_o && !out_stall_i && !s1_valid_q, !out_valid_o)
  `SM83_ASSERT_NEXT(a_wide_op_zero_byte,
                    s1_adv && ((k == sm83alu_pkg::OP_ADD_HL) || (k == sm83alu_pkg::OP_ADD_SP)),
                    out_valid_o && (result_o == 8'd0))

endmodule

@@ verif/tb_sm83_alu_with_flags_unit.sv @@
`timescale 1ns / 1ps

module tb_sm83_alu_with_flags_unit;

  localparam logic [4:0]  KindSpare   = 5'd31;
  localparam int unsigned RandomItems = 1700;
  localparam int unsigned TailCycles  = 12;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DirCount    = 33;

  typedef struct packed {
    sm83alu_pkg::alu_in_t  stim;
    logic                  known;
    sm83alu_pkg::alu_out_t want;
  } dir_row_t;

  typedef struct packed {
    logic [4:0]            kind;
    sm83alu_pkg::alu_out_t want;
  } due_t;

  // Rows with known set carry their result; the rest go through alu_predict.
  localparam dir_row_t DirRows [DirCount] = '{
    '{'{sm83alu_pkg::OP_ADD,    8'hFF, 8'h01, 4'h0, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b1011, 1'b1}},
    '{'{sm83alu_pkg::OP_ADC,    8'h0F, 8'h00, 4'h1, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h10, 16'h0, 4'b0010, 1'b1}},
    '{'{sm83alu_pkg::OP_SUB,    8'h00, 8'h01, 4'h0, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'hFF, 16'h0, 4'b0111, 1'b1}},
    '{'{sm83alu_pkg::OP_SBC,    8'hFF, 8'hFF, 4'h1, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_AND,    8'h0F, 8'hF0, 4'h0, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b1010, 1'b1}},
    '{'{sm83alu_pkg::OP_OR,     8'h00, 8'h00, 4'hF, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b1000, 1'b1}},
    '{'{sm83alu_pkg::OP_XOR,    8'hFF, 8'hFF, 4'hF, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b1000, 1'b1}},
    '{'{sm83alu_pkg::OP_CP,     8'h42, 8'h42, 4'h0, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b1100, 1'b0}},
    '{'{sm83alu_pkg::OP_INC,    8'h00, 8'hFF, 4'h1, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b1011, 1'b1}},
    '{'{sm83alu_pkg::OP_DEC,    8'h00, 8'h00, 4'h0, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'hFF, 16'h0, 4'b0110, 1'b1}},
    '{'{sm83alu_pkg::OP_RLC,    8'h00, 8'h80, 4'h0, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_RRC,    8'h00, 8'h01, 4'h0, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_RL,     8'h00, 8'h80, 4'h0, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b1001, 1'b1}},
    '{'{sm83alu_pkg::OP_RR,     8'h00, 8'h01, 4'h1, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_SLA,    8'h00, 8'h80, 4'h0, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b1001, 1'b1}},
    '{'{sm83alu_pkg::OP_SRA,    8'h00, 8'h81, 4'h0, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_SWAP,   8'h00, 8'hF0, 4'hF, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_SRL,    8'h00, 8'h01, 4'h0, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b1001, 1'b1}},
    '{'{sm83alu_pkg::OP_BIT,    8'h00, 8'h7F, 4'h1, 3'd7, 16'h0, 16'h0},
      1'b1, '{8'h7F, 16'h0, 4'b1011, 1'b0}},
    '{'{sm83alu_pkg::OP_RES,    8'h00, 8'hFF, 4'h5, 3'd7, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_SET,    8'h00, 8'h00, 4'hA, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_DAA,    8'h9A, 8'h00, 4'h0, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b1001, 1'b1}},
    '{'{sm83alu_pkg::OP_DAA,    8'h00, 8'h00, 4'h7, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_CPL,    8'h00, 8'h00, 4'h9, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_CCF,    8'h3C, 8'h00, 4'h1, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_SCF,    8'hC3, 8'h00, 4'h8, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_RLCA,   8'h00, 8'h00, 4'hF, 3'd0, 16'h0, 16'h0},
      1'b1, '{8'h00, 16'h0, 4'b0000, 1'b1}},
    '{'{sm83alu_pkg::OP_RRCA,   8'h01, 8'h00, 4'h0, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_RLA,    8'h80, 8'h00, 4'h0, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_RRA,    8'h01, 8'h00, 4'h1, 3'd0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{sm83alu_pkg::OP_ADD_HL, 8'hAA, 8'h55, 4'h8, 3'd0, 16'hFFFF, 16'h0001}, 1'b1,
      '{8'h00, 16'h0000, 4'b1011, 1'b1}},
    '{'{sm83alu_pkg::OP_ADD_SP, 8'hAA, 8'hFF, 4'hF, 3'd0, 16'h00FF, 16'h1234}, 1'b1,
      '{8'h00, 16'h00FE, 4'b0011, 1'b1}},
    '{'{KindSpare, 8'h55, 8'hAA, 4'hA, 3'd5, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{8'h55, 16'h0000, 4'b1010, 1'b0}}
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [4:0]  kind_i         = '0;
  logic [7:0]  accumulator_i  = '0;
  logic [7:0]  operand_i      = '0;
  logic [3:0]  flags_in_i     = '0;
  logic [2:0]  bit_index_i    = '0;
  logic [15:0] wide_base_i    = '0;
  logic [15:0] wide_operand_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [7:0]  result_o;
  logic [15:0] wide_result_o;
  logic [3:0]  flags_out_o;
  logic        write_back_o;

  logic                  drv_known    = 1'b0;
  sm83alu_pkg::alu_out_t drv_want     = '0;
  due_t                  results_due [$];
  due_t                  due_head;
  int unsigned           mismatch_cnt = 0;
  int unsigned           cycle_cnt    = 0;
  int unsigned           stall_left   = 0;
  int unsigned           stall_mode   = 0;

  sm83_alu_with_flags_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .accumulator_i  (accumulator_i),
    .operand_i      (operand_i),
    .flags_in_i     (flags_in_i),
    .bit_index_i    (bit_index_i),
    .wide_base_i    (wide_base_i),
    .wide_operand_i (wide_operand_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_o       (result_o),
    .wide_result_o  (wide_result_o),
    .flags_out_o    (flags_out_o),
    .write_back_o   (write_back_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic sm83alu_pkg::alu_out_t alu_predict(sm83alu_pkg::alu_in_t x);
    sm83alu_pkg::alu_out_t y;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [7:0]  src;
    logic        cin, t, fz, fn, fh, fc, shift_op;
    cin = x.flags_in[sm83alu_pkg::FlagC];
    fz = x.flags_in[sm83alu_pkg::FlagZ];
    fn = x.flags_in[sm83alu_pkg::FlagN];
    fh = x.flags_in[sm83alu_pkg::FlagH];
    fc = cin;
    shift_op = 1'b0;
    y.result = x.accumulator;
    y.wide_result = '0;
    y.write_back = 1'b1;
    t = (x.kind == sm83alu_pkg::OP_ADC || x.kind == sm83alu_pkg::OP_SBC) ? cin : 1'b0;
    src = (x.kind >= sm83alu_pkg::OP_RLCA && x.kind <= sm83alu_pkg::OP_RRA) ?
          x.accumulator : x.operand;
    case (x.kind)
      sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
        sum9 = {1'b0, x.accumulator} + {1'b0, x.operand} + {8'b0, t};
        nib = {1'b0, x.accumulator[3:0]} + {1'b0, x.operand[3:0]} + {4'b0, t};
        y.result = sum9[7:0];
        {fz, fn, fh, fc} = {sum9[7:0] == 8'h00, 1'b0, nib[4], sum9[8]};
      end
      sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC, sm83alu_pkg::OP_CP: begin
        // a negative difference wraps into the top bit: that is the borrow
        sum9 = {1'b0, x.accumulator} - {1'b0, x.operand} - {8'b0, t};
        nib = {1'b0, x.accumulator[3:0]} - {1'b0, x.operand[3:0]} - {4'b0, t};
        y.result = sum9[7:0];
        y.write_back = (x.kind != sm83alu_pkg::OP_CP);
        {fz, fn, fh, fc} = {sum9[7:0] == 8'h00, 1'b1, nib[4], sum9[8]};
      end
      sm83alu_pkg::OP_AND: begin
        y.result = x.accumulator & x.operand;
        {fz, fn, fh, fc} = {y.result == 8'h00, 3'b010};
      end
      sm83alu_pkg::OP_OR, sm83alu_pkg::OP_XOR: begin
        y.result = (x.kind == sm83alu_pkg::OP_OR) ? (x.accumulator | x.operand)
                                                  : (x.accumulator ^ x.operand);
        {fz, fn, fh, fc} = {y.result == 8'h00, 3'b000};
      end
      sm83alu_pkg::OP_INC: begin
        y.result = x.operand + 8'h01;
        {fz, fn, fh} = {y.result == 8'h00, 1'b0, x.operand[3:0] == 4'hF};
      end
      sm83alu_pkg::OP_DEC: begin
        y.result = x.operand - 8'h01;
        {fz, fn, fh} = {y.result == 8'h00, 1'b1, x.operand[3:0] == 4'h0};
      end
      sm83alu_pkg::OP_RLC, sm83alu_pkg::OP_RLCA: begin
        {fc, y.result} = {src[7], src[6:0], src[7]};
        shift_op = 1'b1;
      end
      sm83alu_pkg::OP_RRC, sm83alu_pkg::OP_RRCA: begin
        {y.result, fc} = {src[0], src};
        shift_op = 1'b1;
      end
      sm83alu_pkg::OP_RL, sm83alu_pkg::OP_RLA: begin
        {fc, y.result} = {src, cin};
        shift_op = 1'b1;
      end
      sm83alu_pkg::OP_RR, sm83alu_pkg::OP_RRA: begin
        {y.result, fc} = {cin, src};
        shift_op = 1'b1;
      end
      sm83alu_pkg::OP_SLA: begin
        {fc, y.result} = {src, 1'b0};
        shift_op = 1'b1;
      end
      sm83alu_pkg::OP_SRA: begin
        {y.result, fc} = {src[7], src};
        shift_op = 1'b1;
      end
      sm83alu_pkg::OP_SRL: begin
        {y.result, fc} = {1'b0, src};
        shift_op = 1'b1;
      end
      sm83alu_pkg::OP_SWAP: begin
        y.result = {src[3:0], src[7:4]};
        fc = 1'b0;
        shift_op = 1'b1;
      end
      sm83alu_pkg::OP_BIT: begin
        y.result = x.operand;
        y.write_back = 1'b0;
        {fz, fn, fh} = {~x.operand[x.bit_index], 2'b01};
      end
      sm83alu_pkg::OP_RES: y.result = x.operand & ~(8'h01 << x.bit_index);
      sm83alu_pkg::OP_SET: y.result = x.operand | (8'h01 << x.bit_index);
      sm83alu_pkg::OP_DAA: begin
        if (x.flags_in[sm83alu_pkg::FlagN]) begin
          if (cin) y.result -= sm83alu_pkg::DaaHiAdj;
          if (x.flags_in[sm83alu_pkg::FlagH]) y.result -= sm83alu_pkg::DaaLoAdj;
        end else begin
          if (cin || x.accumulator > sm83alu_pkg::DaaHiLimit) begin
            y.result += sm83alu_pkg::DaaHiAdj;
            fc = 1'b1;
          end
          if (x.flags_in[sm83alu_pkg::FlagH] ||
              x.accumulator[3:0] > sm83alu_pkg::DaaLoLimit) begin
            y.result += sm83alu_pkg::DaaLoAdj;
          end
        end
        fz = (y.result == 8'h00);
        fh = 1'b0;
      end
      sm83alu_pkg::OP_CPL: begin
        y.result = ~x.accumulator;
        {fn, fh} = 2'b11;
      end
      sm83alu_pkg::OP_CCF: begin
        y.write_back = 1'b0;
        {fn, fh, fc} = {2'b00, ~cin};
      end
      sm83alu_pkg::OP_SCF: begin
        y.write_back = 1'b0;
        {fn, fh, fc} = 3'b001;
      end
      sm83alu_pkg::OP_ADD_HL: begin
        sum17 = {1'b0, x.wide_base} + {1'b0, x.wide_operand};
        sum13 = {1'b0, x.wide_base[11:0]} + {1'b0, x.wide_operand[11:0]};
        y.result = 8'h00;
        y.wide_result = sum17[15:0];
        {fn, fh, fc} = {1'b0, sum13[12], sum17[16]};
      end
      sm83alu_pkg::OP_ADD_SP: begin
        // offset is signed for the sum, but flags come from the unsigned low byte
        nib = {1'b0, x.wide_base[3:0]} + {1'b0, x.operand[3:0]};
        sum9 = {1'b0, x.wide_base[7:0]} + {1'b0, x.operand};
        y.result = 8'h00;
        y.wide_result = x.wide_base + {{8{x.operand[7]}}, x.operand};
        {fz, fn, fh, fc} = {2'b00, nib[4], sum9[8]};
      end
      default: y.write_back = 1'b0;
    endcase
    if (shift_op) begin
      // accumulator forms always clear Z
      fz = (x.kind < sm83alu_pkg::OP_RLCA) && (y.result == 8'h00);
      {fn, fh} = 2'b00;
    end
    y.flags_out[sm83alu_pkg::FlagZ] = fz;
    y.flags_out[sm83alu_pkg::FlagN] = fn;
    y.flags_out[sm83alu_pkg::FlagH] = fh;
    y.flags_out[sm83alu_pkg::FlagC] = fc;
    return y;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {pick_byte(), pick_byte()};
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic sm83alu_pkg::alu_in_t random_item();
    sm83alu_pkg::alu_in_t x;
    x.kind = ($urandom_range(0, 63) == 0) ? KindSpare : 5'($urandom_range(0, 30));
    x.accumulator = pick_byte();
    x.operand = pick_byte();
    x.flags_in = 4'($urandom());
    x.bit_index = 3'($urandom());
    x.wide_base = pick_word();
    x.wide_operand = pick_word();
    return x;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_cnt++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  // Present one operation at a falling edge and hold it until the transfer.
  task automatic send_item(input sm83alu_pkg::alu_in_t x, input logic known,
                           input sm83alu_pkg::alu_out_t want);
    kind_i <= x.kind;
    accumulator_i <= x.accumulator;
    operand_i <= x.operand;
    flags_in_i <= x.flags_in;
    bit_index_i <= x.bit_index;
    wide_base_i <= x.wide_base;
    wide_operand_i <= x.wide_operand;
    drv_known <= known;
    drv_want <= want;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (results_due.size() != 0);
  endtask

  // Check results first, then log the transfer on the input side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing pending", result_o, 0);
        end else begin
          due_head = results_due.pop_front();
          if (result_o !== due_head.want.result)
            report_mismatch($sformatf("kind %0d result", due_head.kind), result_o,
                            due_head.want.result);
          if (wide_result_o !== due_head.want.wide_result)
            report_mismatch($sformatf("kind %0d wide_result", due_head.kind), wide_result_o,
                            due_head.want.wide_result);
          if (flags_out_o !== due_head.want.flags_out)
            report_mismatch($sformatf("kind %0d flags_out", due_head.kind), flags_out_o,
                            due_head.want.flags_out);
          if (write_back_o !== due_head.want.write_back)
            report_mismatch($sformatf("kind %0d write_back", due_head.kind), write_back_o,
                            due_head.want.write_back);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        results_due.push_back('{kind_i, drv_known ? drv_want :
          alu_predict('{kind_i, accumulator_i, operand_i, flags_in_i, bit_index_i,
                        wide_base_i, wide_operand_i})});
      end
    end
  end

  // Receiver: switch between free flow, random stalls and a mostly-stalled rhythm.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= (stall_left[1:0] != 2'b00);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_sm83_alu_with_flags_unit NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (DirRows[i]) begin
      send_item(DirRows[i].stim, DirRows[i].known, DirRows[i].want);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 3));
    end
    drain_results();
    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_item(random_item(), 1'b0, '0);
        sent++;
        // hold off the sender until the pipe is empty once mid-run
        if (sent == RandomItems / 2) drain_results();
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
    end
    drain_results();
    repeat (TailCycles) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_sm83_alu_with_flags_unit OK");
    end else begin
      $display("tb_sm83_alu_with_flags_unit NOT OK");
    end
    $finish;
  end

endmodule
